/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command types and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT    = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_LOCATE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               newline;
    logic               in_range;
    logic [CHAR_W-1:0]  code;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CNT_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [CNT_W-1:0] prod;
    prod = CNT_W'(r) * CNT_W'(COLS);
    return prod + CNT_W'(c);
  endfunction

endpackage

/* src/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input transfers, decodes the kind and pre-classifies the operands.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcw_pkg::KIND_W-1:0]  in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]   in_column,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  tcw_pkg::q_status_t          q_status,
  input  logic                        init_busy,
  output logic                        q_push,
  output tcw_pkg::cmd_t               q_din
);

  logic col_ok;
  logic row_ok;

  assign col_ok = in_column < tcw_pkg::COL_W'(tcw_pkg::COLS);
  assign row_ok = in_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS);

  assign in_stall = q_status.full | init_busy;
  assign q_push   = in_valid & ~in_stall;

  always_comb begin
    q_din.kind     = tcw_pkg::kind_t'(in_kind);
    q_din.newline  = (in_char_code == tcw_pkg::CODE_LF) ||
                     (in_char_code == tcw_pkg::CODE_CR);
    q_din.in_range = col_ok & row_ok;
    q_din.code     = in_char_code;
    q_din.col      = in_column;
    q_din.row      = in_row;
    if (q_din.kind == tcw_pkg::KIND_LOCATE) begin
      if (!col_ok) begin
        q_din.col = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
      end
      if (!row_ok) begin
        q_din.row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
      end
    end
  end

endmodule

/* src/tcw_queue.sv */
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcw_pkg::cmd_t       din,
  input  logic                pop,
  output tcw_pkg::cmd_t       dout,
  output tcw_pkg::q_status_t  status
);

  tcw_pkg::cmd_t                  entries_r [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [tcw_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [tcw_pkg::Q_CNT_W-1:0]    count_r;
  logic [tcw_pkg::Q_PTR_W-1:0]    wr_ptr_nxt;
  logic [tcw_pkg::Q_PTR_W-1:0]    rd_ptr_nxt;
  logic [tcw_pkg::Q_CNT_W-1:0]    count_nxt;

  assign dout         = entries_r[rd_ptr_r];
  assign status.full  = count_r == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH);
  assign status.empty = count_r == '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* src/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the cell memory and cursor; sweeps for clear
// and scroll; holds the result register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data,
  input  tcw_pkg::q_status_t          q_status,
  input  tcw_pkg::cmd_t               q_head,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::OFF_W-1:0]   out_cursor_offset,
  output logic [tcw_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]  out_cell_attribute
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_READW  = 4'b1000
  } state_t;

  localparam logic [tcw_pkg::CNT_W-1:0] LAST_CELL = tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::CNT_W-1:0] CELL_END  = tcw_pkg::CNT_W'(tcw_pkg::CELLS);
  localparam logic [tcw_pkg::CNT_W-1:0] COPY_END  =
    tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
  localparam logic [tcw_pkg::CNT_W-1:0] COLS_C    = tcw_pkg::CNT_W'(tcw_pkg::COLS);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;

  state_t                      state_r, state_nxt;
  logic                        init_r, init_nxt;
  logic [tcw_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [tcw_pkg::COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]   cur_line_r, cur_line_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  attr_r;
  logic                        rd_ok_r, rd_ok_nxt;
  logic                        out_valid_r;
  logic [tcw_pkg::COL_W-1:0]   out_col_r;
  logic [tcw_pkg::ROW_W-1:0]   out_row_r;
  logic [tcw_pkg::OFF_W-1:0]   out_off_r;
  logic [tcw_pkg::CHAR_W-1:0]  out_char_r;
  logic [tcw_pkg::ATTR_W-1:0]  out_attr_r;

  logic                        out_free;
  logic                        load;
  logic [tcw_pkg::CHAR_W-1:0]  ld_char;
  logic [tcw_pkg::ATTR_W-1:0]  ld_attr;
  logic                        we;
  logic [tcw_pkg::CNT_W-1:0]   wa;
  logic [tcw_pkg::CELL_W-1:0]  wd;
  logic [tcw_pkg::CNT_W-1:0]   ra;
  logic [tcw_pkg::CNT_W-1:0]   cur_idx;
  logic [tcw_pkg::CNT_W-1:0]   rd_idx;
  logic [tcw_pkg::CNT_W-1:0]   wr_prev;
  logic [tcw_pkg::CNT_W-1:0]   nxt_idx;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign init_busy = init_r;
  assign cur_idx   = tcw_pkg::cell_index(cur_line_r, cur_col_r);
  assign rd_idx    = tcw_pkg::cell_index(q_head.row, q_head.col);
  assign wr_prev   = cnt_r - 1'b1;
  assign nxt_idx   = tcw_pkg::cell_index(cur_line_nxt, cur_col_nxt);

  always_comb begin
    state_nxt    = state_r;
    init_nxt     = init_r;
    cnt_nxt      = cnt_r;
    cur_col_nxt  = cur_col_r;
    cur_line_nxt = cur_line_r;
    rd_ok_nxt    = rd_ok_r;
    q_pop        = 1'b0;
    load         = 1'b0;
    ld_char      = '0;
    ld_attr      = '0;
    we           = 1'b0;
    wa           = '0;
    wd           = '0;
    ra           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty && out_free) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            tcw_pkg::KIND_PUT: begin
              if (!q_head.newline) begin
                we = 1'b1;
                wa = cur_idx;
                wd = {attr_r, q_head.code};
              end
              if (q_head.newline || cur_col_r == tcw_pkg::COL_W'(tcw_pkg::COLS - 1)) begin
                cur_col_nxt = '0;
                if (cur_line_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                  state_nxt = ST_SCROLL;
                  cnt_nxt   = '0;
                end else begin
                  cur_line_nxt = cur_line_r + 1'b1;
                  load         = 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
                load        = 1'b1;
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              cur_col_nxt  = '0;
              cur_line_nxt = '0;
              cnt_nxt      = '0;
              state_nxt    = ST_CLEAR;
            end
            tcw_pkg::KIND_LOCATE: begin
              cur_col_nxt  = q_head.col;
              cur_line_nxt = q_head.row;
              load         = 1'b1;
            end
            tcw_pkg::KIND_READ: begin
              ra        = q_head.in_range ? rd_idx : '0;
              rd_ok_nxt = q_head.in_range;
              state_nxt = ST_READW;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READW: begin
        load      = 1'b1;
        ld_char   = rd_ok_r ? rd_data_r[tcw_pkg::CHAR_W-1:0] : '0;
        ld_attr   = rd_ok_r ? rd_data_r[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        we = 1'b1;
        wa = cnt_r;
        wd = '0;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
          load      = ~init_r;
          init_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCROLL: begin
        ra = (cnt_r < COPY_END) ? cnt_r + COLS_C : '0;
        if (cnt_r != '0) begin
          we = 1'b1;
          wa = wr_prev;
          wd = (wr_prev < COPY_END) ? rd_data_r : {attr_r, tcw_pkg::CHAR_W'(0)};
        end
        cur_col_nxt  = '0;
        cur_line_nxt = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        if (cnt_r == CELL_END) begin
          cnt_nxt   = '0;
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      cur_col_r   <= '0;
      cur_line_r  <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      init_r     <= init_nxt;
      cnt_r      <= cnt_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_line_r <= cur_line_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= rd_ok_nxt;
    if (load) begin
      out_col_r  <= cur_col_nxt;
      out_row_r  <= cur_line_nxt;
      out_off_r  <= tcw_pkg::OFF_W'(nxt_idx);
      out_char_r <= ld_char;
      out_attr_r <= ld_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[tcw_pkg::ADDR_W-1:0]] <= wd;
    end
    rd_data_r <= mem[ra[tcw_pkg::ADDR_W-1:0]];
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_column  = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_offset  = out_off_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_attribute = out_attr_r;

endmodule

/* src/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell console: decode front, command queue, execution back end.
// ----------------------------------------------------------------------------
// Put that scrolls adds a sweep of the memory, and clear is a sweep of it;
// the one-cell-per-cycle memory sweep covers every cell in both.
// Throughput: one item per cycle for put/locate while neither out_stall nor a
// sweep holds the back end; a read keeps the next command waiting until its
// cell data is loaded. Reset: cursor home, attribute 7; a clearing pass
// zeroes the memory while in_stall is held high.
// ----------------------------------------------------------------------------
module text_console_writer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcw_pkg::KIND_W-1:0]  in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]   in_column,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::OFF_W-1:0]   out_cursor_offset,
  output logic [tcw_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]  out_cell_attribute
);

  tcw_pkg::q_status_t q_status;
  tcw_pkg::cmd_t      q_din;
  tcw_pkg::cmd_t      q_head;
  logic               q_push;
  logic               q_pop;
  logic               init_busy;

  tcw_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .in_column    (in_column),
    .in_row       (in_row),
    .q_status     (q_status),
    .init_busy    (init_busy),
    .q_push       (q_push),
    .q_din        (q_din)
  );

  tcw_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .din    (q_din),
    .pop    (q_pop),
    .dout   (q_head),
    .status (q_status)
  );

  tcw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .q_status           (q_status),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_offset  (out_cursor_offset),
    .out_cell_char      (out_cell_char),
    .out_cell_attribute (out_cell_attribute)
  );

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_column < tcw_pkg::COL_W'(tcw_pkg::COLS)) &&
                  (out_cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
    else $error("cursor outside screen");

  a_offset_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_offset ==
      tcw_pkg::OFF_W'(tcw_pkg::cell_index(out_cursor_row, out_cursor_column)))
    else $error("cursor offset mismatch");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full && !init_busy)
    else $error("queue push while full or initializing");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

endmodule

/* sim/text_console_writer_top_tb.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the character-cell console. A directed table covers
// reset contents, cursor wrap, newline codes, scrolling, clear, locate
// saturation and out-of-range reads; a random phase per attribute setting
// then drives text bursts, locates, reads and clears. A cycle-free predictor
// tracks the screen, cursor and attribute and checks every result in order
// while both channels idle at random, except in one calm phase.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 11;
  localparam int PHASES           = 6;
  localparam int OPS_PER_PHASE    = 250;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES     = 8;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_op_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFF_W-1:0]  offset;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } cursor_report_t;

  typedef struct packed {
    console_op_t    op;
    logic           known;
    cursor_report_t want;
  } console_script_t;

  localparam cursor_report_t BLANK_HOME = '{7'd0, 5'd0, 11'd0, 8'h00, 8'h00};
  localparam cursor_report_t BOTTOM_LEFT = '{7'd0, 5'd24, 11'd1920, 8'h00, 8'h00};
  localparam cursor_report_t ROW1_START = '{7'd0, 5'd1, 11'd80, 8'h00, 8'h00};

  localparam console_script_t DIRECTED [25] = '{
    '{'{KIND_READ,   8'h00, 7'd0,   5'd0 }, 1'b1, BLANK_HOME},
    '{'{KIND_READ,   8'h00, 7'd79,  5'd24}, 1'b1, BLANK_HOME},
    '{'{KIND_READ,   8'hFF, 7'd127, 5'd31}, 1'b1, BLANK_HOME},
    '{'{KIND_PUT,    8'h41, 7'd0,   5'd0 }, 1'b1, '{7'd1, 5'd0, 11'd1, 8'h00, 8'h00}},
    '{'{KIND_READ,   8'h00, 7'd0,   5'd0 }, 1'b1, '{7'd1, 5'd0, 11'd1, 8'h41, 8'h07}},
    '{'{KIND_PUT,    8'hFF, 7'd127, 5'd31}, 1'b1, '{7'd2, 5'd0, 11'd2, 8'h00, 8'h00}},
    '{'{KIND_PUT,    8'h00, 7'd0,   5'd0 }, 1'b1, '{7'd3, 5'd0, 11'd3, 8'h00, 8'h00}},
    '{'{KIND_PUT,    CODE_LF, 7'd0, 5'd0 }, 1'b1, ROW1_START},
    '{'{KIND_PUT,    CODE_CR, 7'd0, 5'd0 }, 1'b1, '{7'd0, 5'd2, 11'd160, 8'h00, 8'h00}},
    '{'{KIND_LOCATE, 8'h00, 7'd127, 5'd31}, 1'b1, '{7'd79, 5'd24, 11'd1999, 8'h00, 8'h00}},
    '{'{KIND_PUT,    8'h5A, 7'd0,   5'd0 }, 1'b1, BOTTOM_LEFT},
    '{'{KIND_READ,   8'h00, 7'd79,  5'd23}, 1'b1, '{7'd0, 5'd24, 11'd1920, 8'h5A, 8'h07}},
    '{'{KIND_READ,   8'h00, 7'd0,   5'd24}, 1'b1, '{7'd0, 5'd24, 11'd1920, 8'h00, 8'h07}},
    '{'{KIND_READ,   8'h00, 7'd0,   5'd0 }, 1'b0, BLANK_HOME},
    '{'{KIND_PUT,    CODE_LF, 7'd0, 5'd0 }, 1'b0, BLANK_HOME},
    '{'{KIND_READ,   8'h00, 7'd79,  5'd22}, 1'b0, BLANK_HOME},
    '{'{KIND_LOCATE, 8'h00, 7'd79,  5'd0 }, 1'b1, '{7'd79, 5'd0, 11'd79, 8'h00, 8'h00}},
    '{'{KIND_PUT,    8'h78, 7'd0,   5'd0 }, 1'b1, ROW1_START},
    '{'{KIND_READ,   8'h00, 7'd80,  5'd0 }, 1'b1, ROW1_START},
    '{'{KIND_READ,   8'h00, 7'd0,   5'd25}, 1'b1, ROW1_START},
    '{'{KIND_READ,   8'h00, 7'd79,  5'd0 }, 1'b0, BLANK_HOME},
    '{'{KIND_CLEAR,  8'hFF, 7'd127, 5'd31}, 1'b1, BLANK_HOME},
    '{'{KIND_READ,   8'h00, 7'd79,  5'd23}, 1'b1, BLANK_HOME},
    '{'{KIND_LOCATE, 8'h00, 7'd0,   5'd24}, 1'b0, BLANK_HOME},
    '{'{KIND_LOCATE, 8'h00, 7'd41,  5'd12}, 1'b0, BLANK_HOME}
  };

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_wr_en    = 1'b0;
  logic [ATTR_W-1:0] cfg_wr_data  = '0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind      = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [COL_W-1:0]  in_column    = '0;
  logic [ROW_W-1:0]  in_row       = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [COL_W-1:0]  out_cursor_column;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [OFF_W-1:0]  out_cursor_offset;
  logic [CHAR_W-1:0] out_cell_char;
  logic [ATTR_W-1:0] out_cell_attribute;

  logic [CELL_W-1:0] screen_model [CELLS];
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ATTR_W-1:0] text_attr;

  cursor_report_t    pending_reports [$];
  cursor_report_t    head_report;
  logic [ATTR_W-1:0] attr_plan [PHASES];
  logic              calm = 1'b0;
  int                mismatches   = 0;
  int                ops_sent     = 0;
  int                reports_seen = 0;
  int                scrolls      = 0;
  int                clears       = 0;
  int                cell_reads   = 0;
  int                quiet_cycles = 0;

  text_console_writer_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_char_code       (in_char_code),
    .in_column          (in_column),
    .in_row             (in_row),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_offset  (out_cursor_offset),
    .out_cell_char      (out_cell_char),
    .out_cell_attribute (out_cell_attribute)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++) begin
      screen_model[i] = screen_model[i + COLS];
    end
    for (int i = CELLS - COLS; i < CELLS; i++) begin
      screen_model[i] = {text_attr, 8'h00};
    end
    cur_col = '0;
    cur_row = ROW_W'(ROWS - 1);
    scrolls++;
  endtask

  task automatic advance_line();
    cur_col = '0;
    if (cur_row == ROW_W'(ROWS - 1)) begin
      scroll_screen();
    end else begin
      cur_row = cur_row + 1'b1;
    end
  endtask

  task automatic console_apply(input console_op_t op, output cursor_report_t rep);
    int pos;
    rep = '0;
    case (op.kind)
      KIND_PUT: begin
        if (op.code == CODE_LF || op.code == CODE_CR) begin
          advance_line();
        end else begin
          pos = int'(cur_row) * COLS + int'(cur_col);
          screen_model[pos] = {text_attr, op.code};
          if (cur_col == COL_W'(COLS - 1)) begin
            advance_line();
          end else begin
            cur_col = cur_col + 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        foreach (screen_model[i]) screen_model[i] = '0;
        cur_col = '0;
        cur_row = '0;
        clears++;
      end
      KIND_LOCATE: begin
        cur_col = (op.col < COLS) ? op.col : COL_W'(COLS - 1);
        cur_row = (op.row < ROWS) ? op.row : ROW_W'(ROWS - 1);
      end
      default: begin
        if (op.col < COLS && op.row < ROWS) begin
          pos = int'(op.row) * COLS + int'(op.col);
          rep.ch   = screen_model[pos][CHAR_W-1:0];
          rep.attr = screen_model[pos][CELL_W-1:CHAR_W];
          cell_reads++;
        end
      end
    endcase
    rep.col    = cur_col;
    rep.row    = cur_row;
    rep.offset = OFF_W'(int'(cur_row) * COLS + int'(cur_col));
  endtask

  function automatic console_op_t random_op();
    console_op_t op;
    int pick;
    op   = '0;
    pick = $urandom_range(99);
    op.code = CHAR_W'($urandom_range(255));
    op.col  = COL_W'($urandom_range(127));
    op.row  = ROW_W'($urandom_range(31));
    if (pick < 50) begin
      op.kind = KIND_PUT;
    end else if (pick < 58) begin
      op.kind = KIND_PUT;
      op.code = $urandom_range(1) ? CODE_LF : CODE_CR;
    end else if (pick < 70) begin
      op.kind = KIND_LOCATE;
      if ($urandom_range(9) != 0) op.col = COL_W'($urandom_range(COLS - 1));
      pick = $urandom_range(9);
      if (pick < 2) op.row = ROW_W'(ROWS - 1);
      else if (pick < 9) op.row = ROW_W'($urandom_range(ROWS - 1));
    end else if (pick < 97) begin
      op.kind = KIND_READ;
      pick = $urandom_range(9);
      if (pick < 6) begin
        op.col = COL_W'($urandom_range(COLS - 1));
        op.row = (cur_row != 0 && $urandom_range(1)) ? cur_row - 1'b1 : cur_row;
      end else if (pick < 9) begin
        op.col = COL_W'($urandom_range(COLS - 1));
        op.row = ROW_W'($urandom_range(ROWS - 1));
      end
    end else begin
      op.kind = KIND_CLEAR;
    end
    return op;
  endfunction

  task automatic send_op(input console_op_t op, input logic known,
                         input cursor_report_t want);
    cursor_report_t rep;
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= op.kind;
    in_char_code <= op.code;
    in_column    <= op.col;
    in_row       <= op.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    console_apply(op, rep);
    pending_reports.push_back(known ? want : rep);
    ops_sent++;
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] attr);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0 || in_stall) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= attr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    text_attr = attr;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s in result %0d: got %0d, want %0d",
             $time, field, reports_seen, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        head_report = pending_reports.pop_front();
        if (out_cursor_column !== head_report.col)
          report_mismatch("cursor_column", out_cursor_column, head_report.col);
        if (out_cursor_row !== head_report.row)
          report_mismatch("cursor_row", out_cursor_row, head_report.row);
        if (out_cursor_offset !== head_report.offset)
          report_mismatch("cursor_offset", out_cursor_offset, head_report.offset);
        if (out_cell_char !== head_report.ch)
          report_mismatch("cell_char", out_cell_char, head_report.ch);
        if (out_cell_attribute !== head_report.attr)
          report_mismatch("cell_attribute", out_cell_attribute, head_report.attr);
      end
      reports_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("text_console_writer_top_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (screen_model[i]) screen_model[i] = '0;
    cur_col   = '0;
    cur_row   = '0;
    text_attr = ATTR_RESET;
    attr_plan = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'h0F};
    attr_plan[4] = ATTR_W'($urandom_range(255));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_op(DIRECTED[i].op, DIRECTED[i].known, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_attribute(attr_plan[p]);
      calm = (p == 2);
      repeat (OPS_PER_PHASE) send_op(random_op(), 1'b0, BLANK_HOME);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands and %0d results over %0d attribute settings",
             ops_sent, reports_seen, PHASES + 1);
    $display("saw %0d scrolls, %0d clears and %0d in-range cell reads",
             scrolls, clears, cell_reads);
    if (mismatches == 0) begin
      $display("text_console_writer_top_tb passed");
    end else begin
      $display("text_console_writer_top_tb failed");
    end
    $finish;
  end

endmodule
